@@ rtl/base36_digit_emitter_macros.svh @@
// assertion macros shared by the base-36 emitter rtl
// no dependencies; included inside module bodies
`ifndef BASE36_DIGIT_EMITTER_MACROS_SVH
`define BASE36_DIGIT_EMITTER_MACROS_SVH

// property must hold at every edge out of reset
`define B36_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("b36 assertion failed");

// expression must never be true out of reset
`define B36_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("b36 forbidden condition");

`endif

@@ rtl/b36_pkg.sv @@
// shared constants, types and the digit-to-ascii map for the base-36 emitter
// no dependencies
package b36_pkg;

    localparam int VALUE_W        = 64;
    localparam int CHAR_W         = 7;
    localparam int COUNT_W        = 4;
    localparam int REM_W          = 6;
    localparam int NIB_W          = 4;
    localparam int RADIX          = 36;
    localparam int MAX_DIGITS_DEF = 13;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic start;
        logic load;
    } t_div_ctl;

    typedef struct packed {
        logic             done;
        logic             q_zero;
        logic [REM_W-1:0] rem;
    } t_div_sts;

    function automatic logic [CHAR_W-1:0] to_ascii(input logic [REM_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < REM_W'(10)) begin
            c = CHAR_W'(8'h30) + {1'b0, d};
        end else if (d < REM_W'(RADIX)) begin
            c = CHAR_W'(8'h57) + {1'b0, d};
        end else begin
            c = CHAR_W'(8'h30);
        end
        return c;
    endfunction

endpackage

@@ rtl/b36_div.sv @@
// serial divide-by-36 unit, one hex digit of the dividend per cycle
// depends on b36_pkg
module b36_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  b36_pkg::t_div_ctl           i_ctl,
    input  logic [b36_pkg::VALUE_W-1:0] i_value,
    output b36_pkg::t_div_sts           o_sts
);
    import b36_pkg::*;

    localparam int STEPS = VALUE_W / NIB_W;
    localparam int CNT_W = $clog2(STEPS);
    localparam int PART_W = REM_W + NIB_W;

    logic [VALUE_W-1:0] r_q, n_q;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic               r_qnz, n_qnz;

    logic [PART_W-1:0]  part;
    logic [NIB_W-1:0]   qd;

    // restoring steps on the partial remainder
    always_comb begin
        part = {r_rem, r_q[VALUE_W-1 -: NIB_W]};
        for (int i = NIB_W - 1; i >= 0; i--) begin
            if (part >= PART_W'(RADIX << i)) begin
                part  = part - PART_W'(RADIX << i);
                qd[i] = 1'b1;
            end else begin
                qd[i] = 1'b0;
            end
        end
    end

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_qnz  = r_qnz;
        n_done = 1'b0;
        if (i_ctl.start) begin
            if (i_ctl.load) begin
                n_q = i_value;
            end
            n_rem  = '0;
            n_cnt  = '0;
            n_qnz  = 1'b0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_q   = {r_q[VALUE_W-NIB_W-1:0], qd};
            n_rem = part[REM_W-1:0];
            n_qnz = r_qnz | (qd != '0);
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_qnz <= n_qnz;
    end

    assign o_sts.done   = r_done;
    assign o_sts.q_zero = !r_qnz;
    assign o_sts.rem    = r_rem;

endmodule

@@ rtl/base36_digit_emitter.sv @@
// each digit is one division pass; the first char is loaded once all D digits (D = 1..13)
// are divided; new values are accepted only in idle, once the last char is loaded;
// the divide-by-36 unit does each pass serially, one hex digit of the dividend per cycle
// reset: synchronous active low, clears control and valid; digit store not cleared
// top level: sequencer, digit store and output register
// depends on b36_pkg, b36_div and base36_digit_emitter_macros.svh
module base36_digit_emitter #(
    parameter int MAX_DIGITS = b36_pkg::MAX_DIGITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [b36_pkg::VALUE_W-1:0] i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [b36_pkg::CHAR_W-1:0]  o_digit_char,
    output logic [b36_pkg::COUNT_W-1:0] o_digit_count,
    output logic                        o_last
);
    import b36_pkg::*;
    `include "base36_digit_emitter_macros.svh"

    localparam int IW = $clog2(MAX_DIGITS);
    localparam int NW = $clog2(MAX_DIGITS + 1);

    t_state           r_state, n_state;
    logic [NW-1:0]    r_n, n_n;
    logic [IW-1:0]    r_idx, n_idx;
    logic             r_ovalid, n_ovalid;
    logic [CHAR_W-1:0]  r_char;
    logic [COUNT_W-1:0] r_count, n_count;
    logic             r_last, n_last;
    logic             store_we;
    logic             out_load;
    logic [REM_W-1:0] r_store [MAX_DIGITS];

    t_div_ctl div_ctl;
    t_div_sts div_sts;

    b36_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_value (i_value),
        .o_sts   (div_sts)
    );

    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_idx    = r_idx;
        n_ovalid = r_ovalid && !i_ready;
        n_count  = r_count;
        n_last   = r_last;
        div_ctl  = '0;
        store_we = 1'b0;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    div_ctl.start = 1'b1;
                    div_ctl.load  = 1'b1;
                    n_n           = '0;
                    n_state       = S_DIV;
                end
            end
            S_DIV: begin
                if (div_sts.done) begin
                    store_we = 1'b1;
                    n_n      = r_n + 1'b1;
                    if (div_sts.q_zero || r_n == NW'(MAX_DIGITS - 1)) begin
                        n_idx   = r_n[IW-1:0];
                        n_state = S_EMIT;
                    end else begin
                        div_ctl.start = 1'b1;
                    end
                end
            end
            S_EMIT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    out_load = 1'b1;
                    n_count  = r_n[COUNT_W-1:0];
                    n_last   = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_n      <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_n      <= n_n;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
        end
        if (out_load) begin
            r_char <= to_ascii(r_store[r_idx]);
        end
        r_count <= n_count;
        r_last  <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_n[IW-1:0]] <= div_sts.rem;
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_ovalid;
    assign o_digit_char  = r_char;
    assign o_digit_count = r_count;
    assign o_last        = r_last;

    `B36_NEVER(a_done_when_idle, i_clk, i_rst_n, div_sts.done && r_state != S_DIV)
    `B36_ASSERT(a_emit_in_range, i_clk, i_rst_n,
        (r_state == S_EMIT) |-> ({1'b0, r_idx} < {1'b0, r_n}))
    `B36_ASSERT(a_store_in_range, i_clk, i_rst_n, store_we |-> (r_n < NW'(MAX_DIGITS)))

endmodule

@@ sim/base36_digit_checker.sv @@
`timescale 1ns / 100ps
// digit checker for the base-36 emitter: predicts the digit words of every accepted
// value and compares them in order with the words the block emits
// depends on b36_pkg
module base36_digit_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [b36_pkg::VALUE_W-1:0]  i_value,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [b36_pkg::CHAR_W-1:0]   i_digit_char,
    input  logic [b36_pkg::COUNT_W-1:0]  i_digit_count,
    input  logic                         i_last,
    output int                           o_errors,
    output int                           o_pending
);
    import b36_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic [COUNT_W-1:0] count;
        logic               last;
    } t_digit_word;

    localparam logic [CHAR_W-1:0] NUMERAL_BASE   = 7'h30;
    localparam logic [CHAR_W-1:0] LETTER_BASE    = 7'h61;
    localparam int                DECIMAL_DIGITS = 10;

    t_digit_word expected_digits[$];
    int          errors;

    function automatic void predict_digits(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] quotient;
        logic [REM_W-1:0]   rems[MAX_DIGITS_DEF];
        int                 n;
        t_digit_word        word;
        quotient = value;
        n = 0;
        do begin
            rems[n] = REM_W'(quotient % VALUE_W'(RADIX));
            quotient = quotient / VALUE_W'(RADIX);
            n++;
        end while (quotient != 0 && n < MAX_DIGITS_DEF);
        // most significant digit first
        for (int k = n - 1; k >= 0; k--) begin
            if (rems[k] < REM_W'(DECIMAL_DIGITS)) begin
                word.ch = NUMERAL_BASE + CHAR_W'(rems[k]);
            end else begin
                word.ch = LETTER_BASE + CHAR_W'(rems[k]) - CHAR_W'(DECIMAL_DIGITS);
            end
            word.count = COUNT_W'(n);
            word.last  = (k == 0);
            expected_digits.push_back(word);
        end
    endfunction

    task automatic note_mismatch(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        errors++;
        $display("%0t mismatch on %s: expected %h, actual %h", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin
        t_digit_word want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (expected_digits.size() == 0) begin
                    errors++;
                    $display("%0t unexpected word: expected none, actual char %h",
                             $time, i_digit_char);
                end else begin
                    want = expected_digits.pop_front();
                    if (i_digit_char !== want.ch) begin
                        note_mismatch("digit_char", 16'(want.ch), 16'(i_digit_char));
                    end
                    if (i_digit_count !== want.count) begin
                        note_mismatch("digit_count", 16'(want.count), 16'(i_digit_count));
                    end
                    if (i_last !== want.last) begin
                        note_mismatch("last", 16'(want.last), 16'(i_last));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_digits(i_value);
            end
        end
        o_errors  <= errors;
        o_pending <= expected_digits.size();
    end

endmodule

@@ sim/base36_digit_emitter_test.sv @@
`timescale 1ns / 100ps
// top of the base-36 emitter testbench: clock, reset, value stimulus, receiver
// stalls and the verdict
// depends on b36_pkg, base36_digit_emitter and base36_digit_checker
module base36_digit_emitter_test;
    import b36_pkg::*;

    localparam int RANDOM_ITEMS = 240;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 800000;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_ready = 1'b0;
    logic [VALUE_W-1:0] i_value = '0;
    logic               o_ready;
    logic               o_valid;
    logic [CHAR_W-1:0]  o_digit_char;
    logic [COUNT_W-1:0] o_digit_count;
    logic               o_last;

    int          errors;
    int          pending;
    int          tx_idle_pct;
    int          rx_idle_pct;
    logic        hold_off_req  = 1'b0;
    bit          hold_off_done = 1'b0;
    int unsigned cycles        = 0;

    base36_digit_emitter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_digit_char  (o_digit_char),
        .o_digit_count (o_digit_count),
        .o_last        (o_last)
    );

    base36_digit_checker digit_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_value       (i_value),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_digit_char  (o_digit_char),
        .i_digit_count (o_digit_count),
        .i_last        (o_last),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // receiver: random stalls plus one long hold-off
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_req && !hold_off_done) begin
                hold_off_done = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
        end
    end

    function automatic logic [VALUE_W-1:0] power_of_36(input int k);
        logic [VALUE_W-1:0] p;
        p = VALUE_W'(1);
        repeat (k) p = p * VALUE_W'(RADIX);
        return p;
    endfunction

    task automatic offer_value(input logic [VALUE_W-1:0] v);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (!o_ready);
    endtask

    initial begin
        logic [VALUE_W-1:0] directed[$];
        logic [VALUE_W-1:0] v;
        int                 w;
        int                 k;
        tx_idle_pct = 37;
        rx_idle_pct <= 60;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed = '{
            64'd0, 64'd1, 64'd9, 64'd10, 64'd35, 64'd36, 64'd37,
            64'd1295, 64'd1296,
            power_of_36(6) - 1, power_of_36(6),
            power_of_36(12) - 1, power_of_36(12), power_of_36(12) + 1,
            64'h8000_0000_0000_0000, 64'hffff_ffff_ffff_fffe,
            64'hffff_ffff_ffff_ffff, 64'haaaa_aaaa_aaaa_aaaa,
            64'h5555_5555_5555_5555, 64'h0000_0000_ffff_ffff
        };
        foreach (directed[i]) begin
            offer_value(directed[i]);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 3) begin
                tx_idle_pct = 60;
                rx_idle_pct <= 37;
            end
            if (i == 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
                hold_off_req <= 1'b1;
            end
            v = {$urandom, $urandom};
            if ($urandom_range(4, 0) == 0) begin
                // straddle a digit-count boundary
                k = $urandom_range(12, 1);
                v = power_of_36(k) + VALUE_W'($urandom_range(2, 0)) - 1;
            end else begin
                w = $urandom_range(64, 0);
                if (w < VALUE_W) begin
                    v = v & ((VALUE_W'(1) << w) - 1);
                end
            end
            offer_value(v);
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
